// File: sv/cfp_pkg.sv
// ---------------------------------------------------------------------------
// cfp_pkg
// Shared widths, face codes and stage records for the cube face unprojection.
// ---------------------------------------------------------------------------
package cfp_pkg;

    localparam int CoefW  = 24;            // Q12.12 coefficient and point
    localparam int SideW  = CoefW + 1;     // point minus coefficient
    localparam int DetW   = 2 * CoefW + 1; // |det| and accepted |num|
    localparam int NumW   = DetW + 1;      // signed numerator
    localparam int FracW  = 16;            // Q2.16 fraction bits
    localparam int QuotW  = FracW + 1;     // quotient magnitude up to 1.0
    localparam int RemW   = DetW + QuotW;  // partial remainder of the divide
    localparam int CoordW = QuotW + 1;     // signed Q2.16 result
    localparam int NumRegs = 6;
    localparam int CfgIdxW = 3;

    localparam logic [CoordW-1:0] OnePos = CoordW'(1 << FracW);
    localparam logic [CoordW-1:0] OneNeg = CoordW'(-(1 << FracW));

    typedef enum logic [1:0] {
        FACE_U = 2'd0,
        FACE_F = 2'd1,
        FACE_R = 2'd2
    } t_face;

    typedef enum logic [CfgIdxW-1:0] {
        REG_SX_FROM_X = 3'd0,
        REG_SX_FROM_Y = 3'd1,
        REG_SX_FROM_Z = 3'd2,
        REG_SY_FROM_X = 3'd3,
        REG_SY_FROM_Y = 3'd4,
        REG_SY_FROM_Z = 3'd5
    } t_reg_idx;

    // per face solve result
    typedef struct packed {
        logic            ok;
        logic [DetW-1:0] adet;
        logic [DetW-1:0] an1;
        logic [DetW-1:0] an2;
        logic            neg1;
        logic            neg2;
    } t_lane;

    // record handed down the divider cells
    typedef struct packed {
        logic             hit;
        t_face            face;
        logic [DetW-1:0]  ad;
        logic [RemW-1:0]  rs;
        logic [RemW-1:0]  rt;
        logic [QuotW-1:0] qs;
        logic [QuotW-1:0] qt;
        logic             ns;
        logic             nt;
    } t_div;

endpackage

// File: sv/cfp_face_lane.sv
// ---------------------------------------------------------------------------
// cfp_face_lane
// Four stage solve of one face: operand capture, products, determinant and numerators, range test.
// ---------------------------------------------------------------------------
module cfp_face_lane (
    input  logic                               i_clk,
    input  logic                               i_en,
    input  logic signed [cfp_pkg::CoefW-1:0]   i_a,
    input  logic signed [cfp_pkg::CoefW-1:0]   i_b,
    input  logic signed [cfp_pkg::CoefW-1:0]   i_c,
    input  logic signed [cfp_pkg::CoefW-1:0]   i_d,
    input  logic signed [cfp_pkg::SideW-1:0]   i_u,
    input  logic signed [cfp_pkg::SideW-1:0]   i_v,
    output cfp_pkg::t_lane                     o_res
);
    import cfp_pkg::*;

    logic signed [CoefW-1:0]     r_a, r_b, r_c, r_d;
    logic signed [SideW-1:0]     r_u, r_v;
    logic signed [2*CoefW-1:0]   r_ad, r_bc;
    logic signed [CoefW+SideW-1:0] r_du, r_bv, r_av, r_cu;
    logic signed [DetW-1:0]      r_det;
    logic signed [NumW-1:0]      r_n1, r_n2;
    logic [DetW-1:0]             det_mag;
    logic [NumW-1:0]             n1_mag, n2_mag;
    t_lane                       n_res, r_res;

    // capture operands
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a <= i_a;
            r_b <= i_b;
            r_c <= i_c;
            r_d <= i_d;
            r_u <= i_u;
            r_v <= i_v;
        end
    end

    // form all products
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ad <= r_a * r_d;
            r_bc <= r_b * r_c;
            r_du <= r_d * r_u;
            r_bv <= r_b * r_v;
            r_av <= r_a * r_v;
            r_cu <= r_c * r_u;
        end
    end

    // determinant and numerators
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_det <= {r_ad[2*CoefW-1], r_ad} - {r_bc[2*CoefW-1], r_bc};
            r_n1  <= {r_du[CoefW+SideW-1], r_du} - {r_bv[CoefW+SideW-1], r_bv};
            r_n2  <= {r_av[CoefW+SideW-1], r_av} - {r_cu[CoefW+SideW-1], r_cu};
        end
    end

    // magnitudes and inclusive range test
    always_comb begin
        det_mag = r_det[DetW-1] ? DetW'(-r_det) : DetW'(r_det);
        n1_mag  = r_n1[NumW-1]  ? NumW'(-r_n1)  : NumW'(r_n1);
        n2_mag  = r_n2[NumW-1]  ? NumW'(-r_n2)  : NumW'(r_n2);
        n_res.ok   = (r_det != '0) && (n1_mag <= NumW'(det_mag))
                     && (n2_mag <= NumW'(det_mag));
        n_res.adet = det_mag;
        n_res.an1  = n1_mag[DetW-1:0];
        n_res.an2  = n2_mag[DetW-1:0];
        n_res.neg1 = r_n1[NumW-1] ^ r_det[DetW-1];
        n_res.neg2 = r_n2[NumW-1] ^ r_det[DetW-1];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_res <= n_res;
        end
    end

    assign o_res = r_res;

endmodule

// File: sv/cfp_div_cell.sv
// ---------------------------------------------------------------------------
// cfp_div_cell
// One restoring divide step for both coordinates, one quotient bit per cell.
// ---------------------------------------------------------------------------
module cfp_div_cell #(
    parameter int BIT = 0
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  cfp_pkg::t_div i_req,
    output cfp_pkg::t_div o_req
);
    import cfp_pkg::*;

    logic [RemW-1:0] dsh;
    t_div            n_req, r_req;

    // trial subtract of the divisor at this bit weight
    always_comb begin
        dsh   = RemW'(i_req.ad) << BIT;
        n_req = i_req;
        if (i_req.rs >= dsh) begin
            n_req.rs      = i_req.rs - dsh;
            n_req.qs[BIT] = 1'b1;
        end
        if (i_req.rt >= dsh) begin
            n_req.rt      = i_req.rt - dsh;
            n_req.qt[BIT] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_req <= n_req;
        end
    end

    assign o_req = r_req;

endmodule

// File: sv/cube_face_unprojection.sv
// ---------------------------------------------------------------------------
// cube_face_unprojection
// Maps a screen point back onto the U, F or R face of the unit cube.
// ---------------------------------------------------------------------------
// One point enters per clock while the output is not stalled. It passes
// through the face solving registers (operand capture, products,
// determinant, range test), the face selection register, seventeen divider
// cells that each settle one quotient bit for both coordinates, and the output register.
// The whole pipeline advances together and holds while the output is
// stalled. Configuration registers are written through the plain port and
// must only change while no point is in flight.
// ---------------------------------------------------------------------------
module cube_face_unprojection (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_wr_en,
    input  logic [cfp_pkg::CfgIdxW-1:0]          i_cfg_index,
    input  logic [cfp_pkg::CoefW-1:0]            i_cfg_data,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic signed [cfp_pkg::CoefW-1:0]     i_point_x,
    input  logic signed [cfp_pkg::CoefW-1:0]     i_point_y,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic                                 o_hit,
    output logic [1:0]                           o_face,
    output logic signed [cfp_pkg::CoordW-1:0]    o_cube_x,
    output logic signed [cfp_pkg::CoordW-1:0]    o_cube_y,
    output logic signed [cfp_pkg::CoordW-1:0]    o_cube_z
);
    import cfp_pkg::*;

    localparam int NumStg = 5 + QuotW;

    logic signed [CoefW-1:0] r_sxx, r_sxy, r_sxz, r_syx, r_syy, r_syz;
    logic                    en;
    logic [NumStg-1:0]       r_vld;
    logic                    r_out_vld;
    t_lane                   lane [3];
    t_div                    n_sel, r_sel;
    t_div                    chain [QuotW+1];
    t_div                    fin;
    logic signed [CoordW-1:0] cs, ct;
    logic                    r_hit;
    logic [1:0]              r_face;
    logic signed [CoordW-1:0] r_cx, r_cy, r_cz;
    logic signed [CoordW-1:0] n_cx, n_cy, n_cz;

    // advance whenever the output register is free or being taken
    assign en      = !r_out_vld || !i_stall;
    assign o_stall = !en;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sxx <= '0; r_sxy <= '0; r_sxz <= '0;
            r_syx <= '0; r_syy <= '0; r_syz <= '0;
        end else if (i_cfg_wr_en) begin
            case (t_reg_idx'(i_cfg_index))
                REG_SX_FROM_X: r_sxx <= i_cfg_data;
                REG_SX_FROM_Y: r_sxy <= i_cfg_data;
                REG_SX_FROM_Z: r_sxz <= i_cfg_data;
                REG_SY_FROM_X: r_syx <= i_cfg_data;
                REG_SY_FROM_Y: r_syy <= i_cfg_data;
                REG_SY_FROM_Z: r_syz <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // request valid tracking
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_vld     <= {r_vld[NumStg-2:0], i_valid};
            r_out_vld <= r_vld[NumStg-1];
        end
    end

    // face U: z fixed at +1
    cfp_face_lane u_lane_u (
        .i_clk(i_clk), .i_en(en),
        .i_a(r_sxx), .i_b(r_sxy), .i_c(r_syx), .i_d(r_syy),
        .i_u(SideW'(i_point_x) - SideW'(r_sxz)),
        .i_v(SideW'(i_point_y) - SideW'(r_syz)),
        .o_res(lane[0])
    );

    // face F: y fixed at -1
    cfp_face_lane u_lane_f (
        .i_clk(i_clk), .i_en(en),
        .i_a(r_sxx), .i_b(r_sxz), .i_c(r_syx), .i_d(r_syz),
        .i_u(SideW'(i_point_x) + SideW'(r_sxy)),
        .i_v(SideW'(i_point_y) + SideW'(r_syy)),
        .o_res(lane[1])
    );

    // face R: x fixed at +1
    cfp_face_lane u_lane_r (
        .i_clk(i_clk), .i_en(en),
        .i_a(r_sxy), .i_b(r_sxz), .i_c(r_syy), .i_d(r_syz),
        .i_u(SideW'(i_point_x) - SideW'(r_sxx)),
        .i_v(SideW'(i_point_y) - SideW'(r_syx)),
        .o_res(lane[2])
    );

    // pick the first face that passes and seed the divider
    always_comb begin
        n_sel      = '0;
        n_sel.face = FACE_U;
        if (lane[0].ok) begin
            n_sel.hit = 1'b1; n_sel.face = FACE_U;
            n_sel.ad = lane[0].adet;
            n_sel.rs = RemW'({lane[0].an1, FracW'(0)}) + RemW'(lane[0].adet >> 1);
            n_sel.rt = RemW'({lane[0].an2, FracW'(0)}) + RemW'(lane[0].adet >> 1);
            n_sel.ns = lane[0].neg1; n_sel.nt = lane[0].neg2;
        end else if (lane[1].ok) begin
            n_sel.hit = 1'b1; n_sel.face = FACE_F;
            n_sel.ad = lane[1].adet;
            n_sel.rs = RemW'({lane[1].an1, FracW'(0)}) + RemW'(lane[1].adet >> 1);
            n_sel.rt = RemW'({lane[1].an2, FracW'(0)}) + RemW'(lane[1].adet >> 1);
            n_sel.ns = lane[1].neg1; n_sel.nt = lane[1].neg2;
        end else if (lane[2].ok) begin
            n_sel.hit = 1'b1; n_sel.face = FACE_R;
            n_sel.ad = lane[2].adet;
            n_sel.rs = RemW'({lane[2].an1, FracW'(0)}) + RemW'(lane[2].adet >> 1);
            n_sel.rt = RemW'({lane[2].an2, FracW'(0)}) + RemW'(lane[2].adet >> 1);
            n_sel.ns = lane[2].neg1; n_sel.nt = lane[2].neg2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sel <= n_sel;
        end
    end

    // divider cells, most significant quotient bit first
    assign chain[0] = r_sel;
    for (genvar j = 0; j < QuotW; j++) begin : g_cell
        cfp_div_cell #(.BIT(QuotW - 1 - j)) u_cell (
            .i_clk(i_clk), .i_en(en),
            .i_req(chain[j]), .o_req(chain[j+1])
        );
    end
    assign fin = chain[QuotW];

    // apply signs and place the fixed coordinate
    always_comb begin
        cs = fin.ns ? -$signed({1'b0, fin.qs}) : $signed({1'b0, fin.qs});
        ct = fin.nt ? -$signed({1'b0, fin.qt}) : $signed({1'b0, fin.qt});
        n_cx = '0; n_cy = '0; n_cz = '0;
        if (fin.hit) begin
            case (fin.face)
                FACE_U: begin n_cx = cs; n_cy = ct; n_cz = OnePos; end
                FACE_F: begin n_cx = cs; n_cy = OneNeg; n_cz = ct; end
                FACE_R: begin n_cx = OnePos; n_cy = cs; n_cz = ct; end
                default: ;
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_hit  <= fin.hit;
            r_face <= fin.hit ? fin.face : FACE_U;
            r_cx   <= n_cx;
            r_cy   <= n_cy;
            r_cz   <= n_cz;
        end
    end

    assign o_valid  = r_out_vld;
    assign o_hit    = r_hit;
    assign o_face   = r_face;
    assign o_cube_x = r_cx;
    assign o_cube_y = r_cy;
    assign o_cube_z = r_cz;

    // a miss carries face U and zero coordinates
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_hit |-> o_face == FACE_U && o_cube_x == '0
                              && o_cube_y == '0 && o_cube_z == '0)
        else $error("miss result not cleared");

    // a hit on U pins z at +1
    a_u_fixed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_hit && o_face == FACE_U |-> o_cube_z == OnePos)
        else $error("U face without z at +1");

    // stall back-pressure follows the output register
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall == (o_valid && i_stall))
        else $error("pipeline stall mismatch");

endmodule

// File: verif/tb_cube_face_unprojection.sv
// ---------------------------------------------------------------------------
// tb_cube_face_unprojection
// Self-checking testbench for the cube face unprojection block.
// ---------------------------------------------------------------------------
// Points go in through the valid/stall request channel and each result is
// checked, field by field, against an in-order queue that is filled by a
// behavioral predictor of the U, F, R face solve. The tests cover reset
// defaults, corner points, degenerate matrices, ignored register indexes,
// a long output hold-off, and random matrices under three idling patterns.
// ---------------------------------------------------------------------------
module tb_cube_face_unprojection;
    timeunit 1ns;
    timeprecision 1ps;
    import cfp_pkg::*;

    localparam int WatchdogLimit = 5000;
    localparam int DrainCycles   = 40;
    localparam int HoldCycles    = 300;
    localparam longint OneQ12    = 4096;
    localparam longint OneQ16    = 65536;

    typedef struct {
        logic              hit;
        logic [1:0]        face;
        logic [CoordW-1:0] cx;
        logic [CoordW-1:0] cy;
        logic [CoordW-1:0] cz;
    } t_cube_point;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_cfg_wr_en = 1'b0;
    logic [CfgIdxW-1:0]       i_cfg_index = '0;
    logic [CoefW-1:0]         i_cfg_data = '0;
    logic                     i_valid = 1'b0;
    logic                     o_stall;
    logic signed [CoefW-1:0]  i_point_x = '0;
    logic signed [CoefW-1:0]  i_point_y = '0;
    logic                     o_valid;
    logic                     i_stall = 1'b0;
    logic                     o_hit;
    logic [1:0]               o_face;
    logic signed [CoordW-1:0] o_cube_x;
    logic signed [CoordW-1:0] o_cube_y;
    logic signed [CoordW-1:0] o_cube_z;

    cube_face_unprojection dut (.*);

    // shadow matrix and checker state
    logic [CoefW-1:0] matrix [NumRegs];
    t_cube_point      pending_points [$];
    int               fail_count = 0;
    int               points_sent = 0;
    int               points_checked = 0;
    int               hits_seen = 0;
    int               tx_idle_pct = 0;
    int               rx_idle_pct = 0;
    int               rx_hold_left = 0;
    int               hold_req = 0;
    int               hold_ack = 0;
    int               quiet_cycles = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic longint coef(int idx);
        return longint'($signed(matrix[idx]));
    endfunction

    // num/det in Q2.16, round to nearest, ties away from zero
    function automatic longint div_round_q16(longint num, longint det);
        longint unsigned an, ad, q;
        an = (num < 0) ? -num : num;
        ad = (det < 0) ? -det : det;
        q = ((an << 16) + (ad >> 1)) / ad;
        return ((num < 0) != (det < 0)) ? -longint'(q) : longint'(q);
    endfunction

    // solve [a b; c d](s,t) = (u,v) and accept when both lie in [-1,1]
    function automatic logic solve_face(longint a, longint b, longint c, longint d,
                                        longint u, longint v,
                                        output longint s, output longint t);
        longint det, n1, n2;
        s = 0;
        t = 0;
        det = a * d - b * c;
        if (det == 0) return 1'b0;
        n1 = d * u - b * v;
        n2 = a * v - c * u;
        if ((n1 < 0 ? -n1 : n1) > (det < 0 ? -det : det)) return 1'b0;
        if ((n2 < 0 ? -n2 : n2) > (det < 0 ? -det : det)) return 1'b0;
        s = div_round_q16(n1, det);
        t = div_round_q16(n2, det);
        return 1'b1;
    endfunction

    function automatic t_cube_point predict_point(logic [CoefW-1:0] x, logic [CoefW-1:0] y);
        t_cube_point r;
        longint px, py, s, t;
        px = longint'($signed(x));
        py = longint'($signed(y));
        r = '{hit: 1'b0, face: FACE_U, cx: '0, cy: '0, cz: '0};
        if (solve_face(coef(0), coef(1), coef(3), coef(4), px - coef(2), py - coef(5), s, t))
            r = '{1'b1, FACE_U, CoordW'(s), CoordW'(t), CoordW'(OneQ16)};
        else if (solve_face(coef(0), coef(2), coef(3), coef(5),
                            px + coef(1), py + coef(4), s, t))
            r = '{1'b1, FACE_F, CoordW'(s), CoordW'(-OneQ16), CoordW'(t)};
        else if (solve_face(coef(1), coef(2), coef(4), coef(5),
                            px - coef(0), py - coef(3), s, t))
            r = '{1'b1, FACE_R, CoordW'(OneQ16), CoordW'(s), CoordW'(t)};
        return r;
    endfunction

    // forward-project a Q12.12 cube point, wrapping to the point width
    task automatic send_cube_point(longint cx, longint cy, longint cz);
        longint sx, sy;
        sx = (coef(0) * cx + coef(1) * cy + coef(2) * cz) >>> 12;
        sy = (coef(3) * cx + coef(4) * cy + coef(5) * cz) >>> 12;
        send_point(CoefW'(sx), CoefW'(sy));
    endtask

    // offer one request, idling first at random, and record its prediction
    task automatic send_point(logic [CoefW-1:0] x, logic [CoefW-1:0] y);
        if ($urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_point_x <= x;
        i_point_y <= y;
        do @(posedge i_clk); while (o_stall);
        pending_points.push_back(predict_point(x, y));
        points_sent++;
    endtask

    task automatic idle_input();
        i_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // drain all results before touching the matrix
    task automatic wait_drained();
        idle_input();
        while (pending_points.size() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
    endtask

    // one register write; the caller drops the enable after the last one
    task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CoefW-1:0] data);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        if (idx < NumRegs) matrix[idx] = data;
    endtask

    task automatic load_matrix(logic [CoefW-1:0] m0, logic [CoefW-1:0] m1,
                               logic [CoefW-1:0] m2, logic [CoefW-1:0] m3,
                               logic [CoefW-1:0] m4, logic [CoefW-1:0] m5);
        wait_drained();
        write_reg(REG_SX_FROM_X, m0);
        write_reg(REG_SX_FROM_Y, m1);
        write_reg(REG_SX_FROM_Z, m2);
        write_reg(REG_SY_FROM_X, m3);
        write_reg(REG_SY_FROM_Y, m4);
        write_reg(REG_SY_FROM_Z, m5);
        i_cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [CoefW-1:0] rand_coef(int style);
        case (style)
            0: return CoefW'($signed($urandom_range(24576)) - 12288);
            1: return CoefW'($urandom);
            default: return $urandom_range(1) ? 24'h7FFFFF : 24'h800000;
        endcase
    endfunction

    task automatic load_random_matrix();
        int style;
        style = ($urandom_range(9) < 7) ? 0 : $urandom_range(2, 1);
        load_matrix(rand_coef(style), rand_coef(style), rand_coef(style),
                    rand_coef(style), rand_coef(style), rand_coef(style));
    endtask

    // random point: mostly on or near a face, the rest anywhere
    task automatic send_random_point();
        longint s, t;
        if ($urandom_range(3) == 0) begin
            send_point(CoefW'($urandom), CoefW'($urandom));
        end else begin
            s = longint'($urandom_range(9000)) - 4500;
            t = longint'($urandom_range(9000)) - 4500;
            case ($urandom_range(2))
                0: send_cube_point(s, t, OneQ12);
                1: send_cube_point(s, -OneQ12, t);
                default: send_cube_point(OneQ12, s, t);
            endcase
        end
    endtask

    // all matrix entries zero: every face is degenerate
    task automatic test_reset_defaults();
        send_point(24'h000000, 24'h000000);
        send_point(24'h7FFFFF, 24'h800000);
        send_point(24'h800000, 24'h7FFFFF);
    endtask

    // corners, edges, face centers and extreme points under a fixed view
    task automatic test_directed_corners();
        load_matrix(24'd4096, -24'd2048, 24'd0, 24'd1024, 24'd1024, 24'd4096);
        send_cube_point(OneQ12, OneQ12, OneQ12);
        send_cube_point(-OneQ12, -OneQ12, OneQ12);
        send_cube_point(OneQ12, -OneQ12, -OneQ12);
        send_cube_point(0, 0, OneQ12);
        send_cube_point(0, -OneQ12, 0);
        send_cube_point(OneQ12, 0, 0);
        send_cube_point(4097, 0, OneQ12);
        send_cube_point(1, 3, OneQ12);
        send_point(24'h7FFFFF, 24'h7FFFFF);
        send_point(24'h800000, 24'h800000);
        send_point(24'h000001, 24'hFFFFFF);
        // every coefficient at an extreme
        load_matrix(24'h7FFFFF, 24'h800000, 24'h7FFFFF, 24'h800000, 24'h800000, 24'h7FFFFF);
        send_point(24'h7FFFFF, 24'h800000);
        send_point(24'h000000, 24'h000000);
        send_point(24'h800000, 24'h7FFFFF);
    endtask

    // x and y columns parallel: U is degenerate, F and R still solve
    task automatic test_degenerate_faces();
        load_matrix(24'd4096, 24'd4096, 24'd0, 24'd2048, 24'd2048, 24'd4096);
        send_cube_point(0, -OneQ12, 0);
        send_cube_point(OneQ12, 0, 2048);
        send_cube_point(0, 0, OneQ12);
        send_point(24'h7FFFFF, 24'h000000);
    endtask

    // writes to indexes six and seven leave the matrix alone
    task automatic test_ignored_indexes();
        wait_drained();
        write_reg(3'd6, CoefW'($urandom));
        write_reg(3'd7, CoefW'($urandom));
        i_cfg_wr_en <= 1'b0;
        repeat (4) send_random_point();
    endtask

    // hold the output while requests keep coming until the input stalls
    task automatic test_output_holdoff();
        load_matrix(24'd4096, -24'd2048, 24'd1024, 24'd1024, 24'd3072, -24'd4096);
        tx_idle_pct = 0;
        hold_req++;
        repeat (60) send_random_point();
    endtask

    task automatic test_random_phase(int tx_pct, int rx_pct, int count);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        for (int i = 0; i < count; i++) begin
            if (i % 40 == 0) load_random_matrix();
            send_random_point();
        end
    endtask

    // receiver: drive stall, check results in order, watch for hangs
    always @(posedge i_clk) begin
        t_cube_point exp_pt;
        if (hold_ack != hold_req) begin
            hold_ack     <= hold_req;
            i_stall      <= 1'b1;
            rx_hold_left <= HoldCycles - 1;
        end else if (rx_hold_left > 0) begin
            i_stall <= 1'b1;
            rx_hold_left <= rx_hold_left - 1;
        end else begin
            i_stall <= ($urandom_range(99) < rx_idle_pct);
        end
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_points.size() == 0) begin
                $error("result with no pending request");
                fail_count++;
            end else begin
                exp_pt = pending_points.pop_front();
                points_checked++;
                if (o_hit) hits_seen++;
                if (o_hit !== exp_pt.hit) begin
                    $error("hit: expected %0d, got %0d", exp_pt.hit, o_hit);
                    fail_count++;
                end
                if (o_face !== exp_pt.face) begin
                    $error("face: expected %0d, got %0d", exp_pt.face, o_face);
                    fail_count++;
                end
                if (o_cube_x !== exp_pt.cx) begin
                    $error("cube_x: expected %0d, got %0d", $signed(exp_pt.cx), o_cube_x);
                    fail_count++;
                end
                if (o_cube_y !== exp_pt.cy) begin
                    $error("cube_y: expected %0d, got %0d", $signed(exp_pt.cy), o_cube_y);
                    fail_count++;
                end
                if (o_cube_z !== exp_pt.cz) begin
                    $error("cube_z: expected %0d, got %0d", $signed(exp_pt.cz), o_cube_z);
                    fail_count++;
                end
            end
        end
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || !i_rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WatchdogLimit) begin
            $display("cube_face_unprojection verification failed");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < NumRegs; i++) matrix[i] = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_defaults();
        test_directed_corners();
        test_degenerate_faces();
        test_ignored_indexes();
        test_output_holdoff();
        test_random_phase(20, 65, 200);
        test_random_phase(65, 20, 200);
        test_random_phase(0, 0, 200);
        wait_drained();
        if (pending_points.size() != 0) fail_count++;
        $display("Covered %0d points (%0d face hits) over reset, corner, degenerate,",
                 points_sent, hits_seen);
        $display("ignored-index, hold-off and random matrix phases; %0d checked.",
                 points_checked);
        if (fail_count == 0)
            $display("cube_face_unprojection verification clean");
        else
            $display("cube_face_unprojection verification failed");
        $finish;
    end

endmodule
